// File: rtl/playfair_digraph_encryptor_macros.svh
// ----------------------------------------------------------------------------
// playfair digraph encryptor assertion macros
// clocked assertions with reset disable, for the port checker
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_MACROS_SVH

// property checked at every clock edge outside reset
`define PFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// types, letter codes, commands and square geometry of the playfair encryptor
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned SqCells    = 25;
  localparam int unsigned NumLetters = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LtrI    = 5'd8;
  localparam letter_t LtrJ    = 5'd9;
  localparam letter_t LtrQ    = 5'd16;
  localparam letter_t LtrX    = 5'd23;
  localparam letter_t LtrLast = 5'd25;
  localparam cell_t   CellLast = 5'd24;
  localparam coord_t  CoordLast = 3'd4;

  typedef enum logic [2:0] {
    CmdClear  = 3'd0,
    CmdKey    = 3'd1,
    CmdFinish = 3'd2,
    CmdText   = 3'd3,
    CmdEnd    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StFill,
    StPosA,
    StPosB,
    StCellA,
    StCellB,
    StOut
  } state_e;

  function automatic coord_t cell_row(cell_t p);
    coord_t r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic coord_t cell_col(cell_t p);
    cell_t rb;
    cell_t diff;
    rb   = cell_t'(cell_row(p));
    diff = p - ((rb << 2) + rb);
    return diff[2:0];
  endfunction

  function automatic cell_t cell_index(coord_t r, coord_t c);
    cell_t rb;
    rb = cell_t'(r);
    return (rb << 2) + rb + cell_t'(c);
  endfunction

  function automatic coord_t wrap_inc(coord_t v);
    return (v == CoordLast) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic letter_t filler_for(letter_t c);
    return (c == LtrX) ? LtrQ : LtrX;
  endfunction

endpackage

// File: rtl/pfe_if.sv
// ----------------------------------------------------------------------------
// pfe_if
// valid/ready channels for command items and cipher pairs
// ----------------------------------------------------------------------------
interface pfe_in_if import pfe_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  letter_t    letter;

  modport source (output valid, output command, output letter, input ready);
  modport sink   (input valid, input command, input letter, output ready);
endinterface

interface pfe_out_if import pfe_pkg::*;;
  logic    valid;
  logic    ready;
  letter_t cipher_first;
  letter_t cipher_second;
  logic    filler_added;

  modport source (output valid, output cipher_first, output cipher_second,
                  output filler_added, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second,
                  input filler_added, output ready);
endinterface

// File: rtl/playfair_digraph_encryptor.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor
// 5x5 key square build and digraph encryption with filler insertion
// ----------------------------------------------------------------------------
// key, clear, text letters that only open a pair: block stays idle and ready
// a pair-closing transfer: ready low through StPosA, StPosB, StCellA, StCellB, StOut
//   (waits for a free output register), set by the single position/square read ports
// finish: StFill scans the alphabet, placing each unused letter but J in turn
// reset: async, clears control and the used mask; memories are not cleared
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor import pfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o
);

  state_e  state_q, state_d;

  letter_t square_mem [SqCells];
  cell_t   pos_mem [NumLetters];
  cell_t   pos_rd_q;
  letter_t sq_rd_q;

  logic [NumLetters-1:0] used_q, used_d;
  cell_t   fill_q, fill_d;
  logic    sq_ready_q, sq_ready_d;
  letter_t pend_q, pend_d;
  logic    pend_valid_q, pend_valid_d;
  letter_t scan_q, scan_d;
  logic    out_valid_q, out_valid_d;

  letter_t a_q, a_d;
  letter_t b_q, b_d;
  logic    filled_q, filled_d;
  cell_t   pa_q;
  cell_t   cell2_q, cell2_d;
  letter_t first_q;
  letter_t out_first_q, out_second_q;
  logic    out_filled_q;

  logic    accept;
  letter_t in_ltr;
  logic    ltr_ok;
  logic    start_enc;
  logic    finish_go;
  logic    out_load;

  logic    place_req;
  letter_t place_ltr;
  logic    place_do;

  cell_t   pos_addr;
  cell_t   sq_addr;
  cell_t   cell1;
  coord_t  ra, ca, rb, cb;

  assign in_ltr = (in_i.letter == LtrJ) ? LtrI : in_i.letter;
  assign ltr_ok = (in_i.letter <= LtrLast);
  assign accept = in_i.valid && in_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (finish_go) state_d = StFill;
        else if (start_enc) state_d = StPosA;
      end
      StFill: begin
        if (scan_q == LtrLast) state_d = StIdle;
      end
      StPosA:  state_d = StPosB;
      StPosB:  state_d = StCellA;
      StCellA: state_d = StCellB;
      StCellB: state_d = StOut;
      StOut: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_i.ready   = (state_q == StIdle);
    start_enc    = 1'b0;
    finish_go    = 1'b0;
    place_req    = 1'b0;
    place_ltr    = in_ltr;
    used_d       = used_q;
    fill_d       = fill_q;
    sq_ready_d   = sq_ready_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    scan_d       = scan_q;
    a_d          = a_q;
    b_d          = b_q;
    filled_d     = filled_q;
    cell2_d      = cell2_q;
    pos_addr     = b_q;
    sq_addr      = cell2_q;
    ra = 3'd0; ca = 3'd0; rb = 3'd0; cb = 3'd0;
    cell1 = 5'd0;

    if (state_q == StIdle && accept) begin
      case (in_i.command)
        CmdClear: begin
          used_d       = '0;
          fill_d       = 5'd0;
          sq_ready_d   = 1'b0;
          pend_d       = 5'd0;
          pend_valid_d = 1'b0;
        end
        CmdKey: begin
          place_req = !sq_ready_q && ltr_ok;
        end
        CmdFinish: begin
          if (!sq_ready_q) begin
            finish_go = 1'b1;
            scan_d    = 5'd0;
          end
        end
        CmdText: begin
          if (sq_ready_q && ltr_ok) begin
            if (!pend_valid_q) begin
              pend_d       = in_ltr;
              pend_valid_d = 1'b1;
            end else begin
              start_enc = 1'b1;
              a_d       = pend_q;
              if (pend_q == in_ltr) begin
                b_d      = filler_for(pend_q);
                filled_d = 1'b1;
              end else begin
                b_d          = in_ltr;
                filled_d     = 1'b0;
                pend_d       = 5'd0;
                pend_valid_d = 1'b0;
              end
            end
          end
        end
        CmdEnd: begin
          if (sq_ready_q && pend_valid_q) begin
            start_enc    = 1'b1;
            a_d          = pend_q;
            b_d          = filler_for(pend_q);
            filled_d     = 1'b1;
            pend_d       = 5'd0;
            pend_valid_d = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (state_q == StFill) begin
      place_req = 1'b1;
      place_ltr = scan_q;
      scan_d    = scan_q + 5'd1;
      if (scan_q == LtrLast) sq_ready_d = 1'b1;
    end

    if (state_q == StPosA) pos_addr = a_q;

    if (state_q == StCellA) begin
      ra = cell_row(pa_q);
      ca = cell_col(pa_q);
      rb = cell_row(pos_rd_q);
      cb = cell_col(pos_rd_q);
      if (ra == rb) begin
        cell1   = cell_index(ra, wrap_inc(ca));
        cell2_d = cell_index(rb, wrap_inc(cb));
      end else if (ca == cb) begin
        cell1   = cell_index(wrap_inc(ra), ca);
        cell2_d = cell_index(wrap_inc(rb), cb);
      end else begin
        cell1   = cell_index(ra, cb);
        cell2_d = cell_index(rb, ca);
      end
      sq_addr = cell1;
    end

    place_do = place_req && (place_ltr != LtrJ) && (fill_q <= CellLast)
               && !used_q[place_ltr];
    if (place_do) begin
      used_d[place_ltr] = 1'b1;
      fill_d            = fill_q + 5'd1;
    end

    out_load    = (state_q == StOut) && (!out_valid_q || out_o.ready);
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      used_q       <= '0;
      fill_q       <= 5'd0;
      sq_ready_q   <= 1'b0;
      pend_q       <= 5'd0;
      pend_valid_q <= 1'b0;
      scan_q       <= 5'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      fill_q       <= fill_d;
      sq_ready_q   <= sq_ready_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      scan_q       <= scan_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // key square and letter position memories
  always_ff @(posedge clk_i) begin
    if (place_do) begin
      square_mem[fill_q]  <= place_ltr;
      pos_mem[place_ltr]  <= fill_q;
    end
    pos_rd_q <= pos_mem[pos_addr];
    sq_rd_q  <= square_mem[sq_addr];
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    filled_q <= filled_d;
    cell2_q  <= cell2_d;
    if (state_q == StPosB) pa_q <= pos_rd_q;
    if (state_q == StCellB) first_q <= sq_rd_q;
    if (out_load) begin
      out_first_q  <= first_q;
      out_second_q <= sq_rd_q;
      out_filled_q <= filled_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cipher_first  = out_first_q;
  assign out_o.cipher_second = out_second_q;
  assign out_o.filler_added  = out_filled_q;

endmodule

// File: rtl/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker
// port level checks of the playfair encryptor, bound to the top level
// ----------------------------------------------------------------------------
`include "playfair_digraph_encryptor_macros.svh"

module pfe_checker import pfe_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input letter_t cipher_first_i,
  input letter_t cipher_second_i,
  input logic    filler_added_i
);

  // stalled result holds until transfer
  `PFE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(cipher_first_i) && $stable(cipher_second_i) && $stable(filler_added_i), "stalled result changed")

  `PFE_ASSERT(a_letter_range, out_valid_i |-> cipher_first_i != LtrJ && cipher_second_i != LtrJ && cipher_first_i <= LtrLast && cipher_second_i <= LtrLast, "cipher letter out of the square")

  // two distinct cells always map to two distinct cells
  `PFE_ASSERT(a_pair_distinct, out_valid_i |-> cipher_first_i != cipher_second_i, "cipher pair letters equal")

  `PFE_ASSERT(a_busy_before_result, $rose(out_valid_i) |-> !$past(in_ready_i), "result without busy cycle")

endmodule

bind playfair_digraph_encryptor pfe_checker u_pfe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .cipher_first_i  (out_o.cipher_first),
  .cipher_second_i (out_o.cipher_second),
  .filler_added_i  (out_o.filler_added)
);
